// File: sv/grid_neighbor_peer_table_macros.svh
// assertion macros for the grid neighbor peer table checker
// depends on nothing; included by the checker file only
`ifndef GRID_NEIGHBOR_PEER_TABLE_MACROS_SVH
`define GRID_NEIGHBOR_PEER_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define GNPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define GNPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/gnpt_pkg.sv
// shared types and constants for the grid neighbor peer table
// no dependencies; imported by every module of the block
`default_nettype none

package gnpt_pkg;

   // field widths
   localparam int KIND_W = 2;
   localparam int PEER_W = 32;
   localparam int POS_W  = 24;
   localparam int CELL_W = 24;
   localparam int SIZE_W = 23;
   localparam int STAT_W = 2;
   localparam int DIFF_W = CELL_W + 1;

   // stream packing
   localparam int REQ_BITS   = PEER_W + 2 * POS_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = STAT_W + PEER_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // table size default and config reset
   localparam int MAX_PEERS_DEF = 64;
   localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = SIZE_W'(256);

   // divider: one quotient bit per step
   localparam int DIV_STEPS = POS_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // neighborhood reach in cells
   localparam logic signed [DIFF_W-1:0] NEAR_LO = DIFF_W'(-2);
   localparam logic signed [DIFF_W-1:0] NEAR_HI = DIFF_W'(2);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PLACE  = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_REMOVE = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_QUERY  = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_NONE   = KIND_W'(3);

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK      = STAT_W'(0);
   localparam logic [STAT_W-1:0] STAT_CHANGED = STAT_W'(1);
   localparam logic [STAT_W-1:0] STAT_FULL    = STAT_W'(2);
   localparam logic [STAT_W-1:0] STAT_ABSENT  = STAT_W'(3);

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_X,
      S_DIV_Y,
      S_SCAN,
      S_FINISH
   } seq_state_type;

   // table control from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic set_valid;
      logic clr_valid;
   } tbl_ctl_type;

endpackage

`default_nettype wire

// File: sv/gnpt_div.sv
// shared restoring divider: position to grid cell with floor rounding
// depends on gnpt_pkg
`default_nettype none

module gnpt_div
   import gnpt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [POS_W-1:0]  pos,
   input  logic        [SIZE_W-1:0] divisor,
   output logic                     done,
   output logic signed [CELL_W-1:0] cell_idx
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [POS_W-1:0]  quo_ff, quo_in;
   logic [SIZE_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [CELL_W-1:0] cell_ff, cell_in;

   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;
   logic              fits;
   logic [SIZE_W-1:0] rem_next;
   logic [POS_W-1:0]  quo_next;
   logic [POS_W-1:0]  mag;
   logic              round_up;
   logic [POS_W:0]    qsum;
   logic [POS_W:0]    qneg;
   logic              last_step;

   // one quotient bit per cycle
   always_comb begin
      trial     = {rem_ff, quo_ff[POS_W-1]};
      diff      = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};
      rem_next  = fits ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      quo_next  = {quo_ff[POS_W-2:0], fits};
      last_step = step_ff == STEP_W'(DIV_STEPS - 1);
      // negative positions round toward minus infinity
      round_up  = neg_ff && (rem_next != '0);
      qsum      = {1'b0, quo_next} + (POS_W+1)'(round_up);
      qneg      = ~qsum + (POS_W+1)'(1);
      mag       = pos[POS_W-1] ? (~pos + POS_W'(1)) : pos;
   end

   // sequencing of the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cell_in = cell_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = mag;
         dvs_in  = divisor;
         neg_in  = pos[POS_W-1];
      end else if (busy_ff) begin
         rem_in  = rem_next;
         quo_in  = quo_next;
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cell_in = neg_ff ? qneg[CELL_W-1:0] : qsum[CELL_W-1:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      cell_ff <= cell_in;
   end

   assign done     = done_ff;
   assign cell_idx = cell_ff;

endmodule

`default_nettype wire

// File: sv/gnpt_table.sv
// peer table: valid bits in flops, peer and cell in a one-port-each memory
// depends on gnpt_pkg
`default_nettype none

module gnpt_table
   import gnpt_pkg::*;
#(
   parameter int MAX_PEERS = MAX_PEERS_DEF,
   parameter int IDX_W     = $clog2(MAX_PEERS)
)(
   input  logic                     clock,
   input  logic                     reset,
   input  tbl_ctl_type              ctl,
   input  logic [IDX_W-1:0]         rd_addr,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [PEER_W-1:0]        wr_peer,
   input  logic signed [CELL_W-1:0] wr_cx,
   input  logic signed [CELL_W-1:0] wr_cy,
   output logic                     rd_valid,
   output logic [PEER_W-1:0]        rd_peer,
   output logic signed [CELL_W-1:0] rd_cx,
   output logic signed [CELL_W-1:0] rd_cy
);

   localparam int ENT_W = PEER_W + 2 * CELL_W;

   logic [MAX_PEERS-1:0] valid_ff;
   logic [ENT_W-1:0]     entry_mem_ff [MAX_PEERS];
   logic [ENT_W-1:0]     rd_data_ff;
   logic                 rd_valid_ff;

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.set_valid) begin
         valid_ff[wr_addr] <= 1'b1;
      end else if (ctl.clr_valid) begin
         valid_ff[wr_addr] <= 1'b0;
      end
   end

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem_ff[wr_addr] <= {wr_peer, wr_cx, wr_cy};
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= entry_mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_peer  = rd_data_ff[2*CELL_W +: PEER_W];
   assign rd_cx    = rd_data_ff[CELL_W +: CELL_W];
   assign rd_cy    = rd_data_ff[CELL_W-1:0];

endmodule

`default_nettype wire

// File: sv/gnpt_ctrl.sv
// sequencer: cell division, table scan, table update and result register
// depends on gnpt_pkg; drives gnpt_div and gnpt_table
`default_nettype none

module gnpt_ctrl
   import gnpt_pkg::*;
#(
   parameter int MAX_PEERS = MAX_PEERS_DEF,
   parameter int IDX_W     = $clog2(MAX_PEERS),
   parameter int CNT_W     = $clog2(MAX_PEERS + 1)
)(
   input  logic                     clock,
   input  logic                     reset,
   // item side
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [PEER_W-1:0]        req_peer,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   // divider
   output logic                     div_start,
   output logic signed [POS_W-1:0]  div_pos,
   input  logic                     div_done,
   input  logic signed [CELL_W-1:0] div_cell,
   // table
   output tbl_ctl_type              tbl_ctl,
   output logic [IDX_W-1:0]         tbl_rd_addr,
   output logic [IDX_W-1:0]         tbl_wr_addr,
   output logic [PEER_W-1:0]        tbl_wr_peer,
   output logic signed [CELL_W-1:0] tbl_wr_cx,
   output logic signed [CELL_W-1:0] tbl_wr_cy,
   input  logic                     tbl_rd_valid,
   input  logic [PEER_W-1:0]        tbl_rd_peer,
   input  logic signed [CELL_W-1:0] tbl_rd_cx,
   input  logic signed [CELL_W-1:0] tbl_rd_cy,
   // result side
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_found,
   output logic [PEER_W-1:0]        rsp_peer,
   output logic                     rsp_last
);

   seq_state_type state_ff, state_in;

   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [PEER_W-1:0]        id_ff, id_in;
   logic signed [POS_W-1:0]  posy_ff, posy_in;
   logic signed [CELL_W-1:0] cx_ff, cx_in;
   logic signed [CELL_W-1:0] cy_ff, cy_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]         ev_idx_ff, ev_idx_in;
   logic                     match_ff, match_in;
   logic [IDX_W-1:0]         match_idx_ff, match_idx_in;
   logic                     chg_ff, chg_in;
   logic                     free_ff, free_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic                     pend_vld_ff, pend_vld_in;
   logic [PEER_W-1:0]        pend_peer_ff, pend_peer_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [PEER_W-1:0]        rsp_peer_ff, rsp_peer_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     is_query;
   logic                     is_place;
   logic                     out_ok;
   logic                     e_match;
   logic                     e_near;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic                     stall;
   logic                     issue;
   logic                     advance;
   logic                     scan_end;
   logic                     push;
   logic [STAT_W-1:0]        push_status;
   logic                     push_found;
   logic [PEER_W-1:0]        push_peer;
   logic                     push_last;

   // entry evaluation and scan handshakes
   always_comb begin
      is_query = kind_ff == KIND_QUERY;
      is_place = kind_ff == KIND_PLACE;
      out_ok   = !rsp_valid_ff || rsp_ready;
      e_match  = tbl_rd_valid && (tbl_rd_peer == id_ff);
      dx       = {tbl_rd_cx[CELL_W-1], tbl_rd_cx} - {cx_ff[CELL_W-1], cx_ff};
      dy       = {tbl_rd_cy[CELL_W-1], tbl_rd_cy} - {cy_ff[CELL_W-1], cy_ff};
      e_near   = tbl_rd_valid && !e_match && (dx >= NEAR_LO) && (dx <= NEAR_HI)
                 && (dy >= NEAR_LO) && (dy <= NEAR_HI);
      // a second hit needs the result register for the one held back
      stall    = ev_vld_ff && is_query && e_near && pend_vld_ff && !out_ok;
      advance  = (state_ff == S_SCAN) && !stall;
      issue    = advance && (rd_idx_ff < CNT_W'(MAX_PEERS));
      scan_end = (state_ff == S_SCAN) && !ev_vld_ff && (rd_idx_ff == CNT_W'(MAX_PEERS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_PLACE:  state_in = S_DIV_X;
                  KIND_QUERY:  state_in = S_DIV_X;
                  KIND_REMOVE: state_in = S_SCAN;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_DIV_X: begin
            if (div_done) state_in = S_DIV_Y;
         end
         S_DIV_Y: begin
            if (div_done) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_end) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_ok) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready         = state_ff == S_IDLE;
      div_start         = 1'b0;
      div_pos           = (state_ff == S_IDLE) ? req_pos_x : posy_ff;
      tbl_ctl           = '0;
      tbl_ctl.rd_en     = issue;
      tbl_rd_addr       = rd_idx_ff[IDX_W-1:0];
      tbl_wr_addr       = match_ff ? match_idx_ff : free_idx_ff;
      tbl_wr_peer       = id_ff;
      tbl_wr_cx         = cx_ff;
      tbl_wr_cy         = cy_ff;
      push              = 1'b0;
      push_status       = STAT_OK;
      push_found        = 1'b0;
      push_peer         = '0;
      push_last         = 1'b1;
      case (state_ff)
         S_IDLE: begin
            div_start = req_valid && ((req_kind == KIND_PLACE) || (req_kind == KIND_QUERY));
         end
         S_DIV_X: begin
            div_start = div_done;
         end
         S_SCAN: begin
            // a new hit releases the one held back, which is not the last
            if (advance && ev_vld_ff && is_query && e_near && pend_vld_ff) begin
               push       = 1'b1;
               push_found = 1'b1;
               push_peer  = pend_peer_ff;
               push_last  = 1'b0;
            end
         end
         S_FINISH: begin
            push = out_ok;
            if (is_query) begin
               push_found  = pend_vld_ff;
               push_peer   = pend_vld_ff ? pend_peer_ff : '0;
               push_status = pend_vld_ff ? STAT_OK : STAT_ABSENT;
            end else if (is_place) begin
               if (match_ff) begin
                  push_status   = chg_ff ? STAT_CHANGED : STAT_OK;
                  tbl_ctl.wr_en = out_ok;
               end else if (free_ff) begin
                  push_status       = STAT_CHANGED;
                  tbl_ctl.wr_en     = out_ok;
                  tbl_ctl.set_valid = out_ok;
               end else begin
                  push_status = STAT_FULL;
               end
            end else begin
               push_status       = match_ff ? STAT_OK : STAT_ABSENT;
               tbl_ctl.clr_valid = out_ok && match_ff;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      kind_in       = kind_ff;
      id_in         = id_ff;
      posy_in       = posy_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      rd_idx_in     = rd_idx_ff;
      ev_vld_in     = ev_vld_ff;
      ev_idx_in     = ev_idx_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      chg_in        = chg_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_peer_in  = pend_peer_ff;
      // item capture clears the scan bookkeeping
      if ((state_ff == S_IDLE) && req_valid) begin
         kind_in     = req_kind;
         id_in       = req_peer;
         posy_in     = req_pos_y;
         rd_idx_in   = '0;
         ev_vld_in   = 1'b0;
         match_in    = 1'b0;
         free_in     = 1'b0;
         pend_vld_in = 1'b0;
      end
      if ((state_ff == S_DIV_X) && div_done) cx_in = div_cell;
      if ((state_ff == S_DIV_Y) && div_done) cy_in = div_cell;
      // one entry a cycle through the read register while the scan is not stalled
      if (advance) begin
         rd_idx_in = issue ? (rd_idx_ff + CNT_W'(1)) : rd_idx_ff;
         ev_vld_in = issue;
         ev_idx_in = rd_idx_ff[IDX_W-1:0];
         if (ev_vld_ff) begin
            if (e_match && !match_ff) begin
               match_in     = 1'b1;
               match_idx_in = ev_idx_ff;
               chg_in       = (tbl_rd_cx != cx_ff) || (tbl_rd_cy != cy_ff);
            end
            if (!tbl_rd_valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = ev_idx_ff;
            end
            if (is_query && e_near) begin
               pend_vld_in  = 1'b1;
               pend_peer_in = tbl_rd_peer;
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_peer_in   = rsp_peer_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = push_status;
         rsp_found_in  = push_found;
         rsp_peer_in   = push_peer;
         rsp_last_in   = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ev_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ev_vld_ff    <= ev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      posy_ff       <= posy_in;
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      rd_idx_ff     <= rd_idx_in;
      ev_idx_ff     <= ev_idx_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      chg_ff        <= chg_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      pend_vld_ff   <= pend_vld_in;
      pend_peer_ff  <= pend_peer_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_peer_ff   <= rsp_peer_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_peer   = rsp_peer_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/grid_neighbor_peer_table.sv
// Place and query first divide both positions on the shared 24-step divider, once per axis;
// all kinds then scan the table, one entry a cycle unless a held-back hit waits for the
// result register. One item at a time: ready again the cycle after the final result enters
// the output register. Hits leave as the scan finds them, each held until the next or the end.
// Reset: synchronous, active high; clears all valid bits at once, sets cell_size to 256.
// depends on gnpt_pkg, gnpt_div, gnpt_table, gnpt_ctrl
`default_nettype none

module grid_neighbor_peer_table
   import gnpt_pkg::*;
#(
   parameter int MAX_PEERS = MAX_PEERS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   // item beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // peer_id[31:0], pos_x[55:32], pos_y[79:56]
   input  logic [KIND_W-1:0]     req_tuser,   // kind[1:0]
   // result beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status[1:0], found_peer[33:2], zero pad
   output logic [0:0]            rsp_tuser,   // found[0]
   output logic                  rsp_tlast,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [SIZE_W-1:0]     csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_PEERS);
   localparam int CNT_W = $clog2(MAX_PEERS + 1);

   logic [SIZE_W-1:0]        cell_size_ff;
   logic [SIZE_W-1:0]        divisor;
   logic                     div_start;
   logic signed [POS_W-1:0]  div_pos;
   logic                     div_done;
   logic signed [CELL_W-1:0] div_cell;
   tbl_ctl_type              tbl_ctl;
   logic [IDX_W-1:0]         tbl_rd_addr;
   logic [IDX_W-1:0]         tbl_wr_addr;
   logic [PEER_W-1:0]        tbl_wr_peer;
   logic signed [CELL_W-1:0] tbl_wr_cx;
   logic signed [CELL_W-1:0] tbl_wr_cy;
   logic                     tbl_rd_valid;
   logic [PEER_W-1:0]        tbl_rd_peer;
   logic signed [CELL_W-1:0] tbl_rd_cx;
   logic signed [CELL_W-1:0] tbl_rd_cy;
   logic [STAT_W-1:0]        rsp_status;
   logic [PEER_W-1:0]        rsp_peer;
   logic                     rsp_found;

   // cell size register
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CELL_SIZE_RESET;
      end else if (csr_wr_en) begin
         cell_size_ff <= csr_wr_data;
      end
   end

   // a zero cell size divides as one
   assign divisor = (cell_size_ff == '0) ? SIZE_W'(1) : cell_size_ff;

   gnpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .pos      (div_pos),
      .divisor  (divisor),
      .done     (div_done),
      .cell_idx (div_cell)
   );

   gnpt_table #(
      .MAX_PEERS (MAX_PEERS),
      .IDX_W     (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .rd_addr  (tbl_rd_addr),
      .wr_addr  (tbl_wr_addr),
      .wr_peer  (tbl_wr_peer),
      .wr_cx    (tbl_wr_cx),
      .wr_cy    (tbl_wr_cy),
      .rd_valid (tbl_rd_valid),
      .rd_peer  (tbl_rd_peer),
      .rd_cx    (tbl_rd_cx),
      .rd_cy    (tbl_rd_cy)
   );

   gnpt_ctrl #(
      .MAX_PEERS (MAX_PEERS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .req_peer     (req_tdata[PEER_W-1:0]),
      .req_pos_x    (req_tdata[PEER_W +: POS_W]),
      .req_pos_y    (req_tdata[PEER_W+POS_W +: POS_W]),
      .div_start    (div_start),
      .div_pos      (div_pos),
      .div_done     (div_done),
      .div_cell     (div_cell),
      .tbl_ctl      (tbl_ctl),
      .tbl_rd_addr  (tbl_rd_addr),
      .tbl_wr_addr  (tbl_wr_addr),
      .tbl_wr_peer  (tbl_wr_peer),
      .tbl_wr_cx    (tbl_wr_cx),
      .tbl_wr_cy    (tbl_wr_cy),
      .tbl_rd_valid (tbl_rd_valid),
      .tbl_rd_peer  (tbl_rd_peer),
      .tbl_rd_cx    (tbl_rd_cx),
      .tbl_rd_cy    (tbl_rd_cy),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_peer     (rsp_peer),
      .rsp_last     (rsp_tlast)
   );

   // result beat packing
   assign rsp_tdata = {(RSP_DATA_W-RSP_BITS)'(0), rsp_peer, rsp_status};
   assign rsp_tuser = rsp_found;

endmodule

`default_nettype wire

// File: sv/gnpt_checker.sv
// port-level checks for grid_neighbor_peer_table, bound to the top level
// depends on gnpt_pkg and grid_neighbor_peer_table_macros.svh
`default_nettype none
`include "grid_neighbor_peer_table_macros.svh"

module gnpt_checker
   import gnpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [0:0]            rsp_tuser,
   input  logic                  rsp_tlast
);

   logic req_beat_real;
   logic rsp_stalled;

   assign req_beat_real = req_tvalid && req_tready && (req_tuser != KIND_NONE);
   assign rsp_stalled   = rsp_tvalid && !rsp_tready;

   // a stalled result beat holds
   `GNPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result beat changed while stalled")

   // an accepted item keeps the block busy for the next cycle
   `GNPT_ASSERT_NEXT(a_busy_after_item, clock, reset, req_beat_real, !req_tready, "item accepted while previous one is in work")

   // a beat without a neighbor is always the final one and carries no peer
   `GNPT_ASSERT_NOW(a_plain_last, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tlast && (rsp_tdata[STAT_W +: PEER_W] == '0), "plain result not final or peer not zero")

   // a neighbor beat carries the ok status
   `GNPT_ASSERT_NOW(a_found_ok, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[STAT_W-1:0] == STAT_OK, "neighbor result with non-ok status")

endmodule

bind grid_neighbor_peer_table gnpt_checker u_gnpt_checker (.*);

`default_nettype wire

// File: bench/tb_grid_neighbor_peer_table.sv
// self-checking bench for grid_neighbor_peer_table: directed and random place, remove
// and query beats across several cell sizes, each result checked against a software table
// depends on gnpt_pkg and the grid_neighbor_peer_table rtl
`default_nettype none

module tb_grid_neighbor_peer_table;
   import gnpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     TABLE_DEPTH   = MAX_PEERS_DEF;
   localparam int     REACH         = 2;
   localparam int     POOL_SIZE     = 96;
   localparam int     SETTLE_CYCLES = 200;
   localparam int     HOLD_AT       = 150;
   localparam int     HOLD_CYCLES   = 600;
   localparam int     PHASE_ITEMS   = 65;
   localparam longint CYCLE_LIMIT   = 1_200_000;
   localparam longint POS_MAX       = 64'sd8388607;
   localparam longint POS_MIN       = -64'sd8388608;

   // one result beat as seen on the result channel
   typedef struct {
      logic [STAT_W-1:0] status;
      logic              found;
      logic [PEER_W-1:0] peer;
      logic              last;
   } peer_reply_type;

   // software copy of the peer table; predicts and checks result beats
   class peer_grid_tracker;
      bit                live  [TABLE_DEPTH];
      logic [PEER_W-1:0] who   [TABLE_DEPTH];
      int                at_x  [TABLE_DEPTH];
      int                at_y  [TABLE_DEPTH];
      logic [SIZE_W-1:0] cell_size;
      peer_reply_type    replies_due[$];
      int errors, beats, hits, fulls, places, removes, queries, ignored;

      function new();
         cell_size = CELL_SIZE_RESET;
         foreach (live[i]) live[i] = 1'b0;
      endfunction

      // floor division of a signed position, zero size acts as one
      function int to_cell(logic signed [POS_W-1:0] p);
         longint s;
         longint m;
         s = (cell_size == 0) ? 1 : longint'(cell_size);
         if (p >= 0) return int'(longint'(p) / s);
         m = -longint'(p);
         return -int'((m + s - 1) / s);
      endfunction

      function int slot_of(logic [PEER_W-1:0] id);
         for (int i = 0; i < TABLE_DEPTH; i++)
            if (live[i] && who[i] == id) return i;
         return -1;
      endfunction

      function void push_due(logic [STAT_W-1:0] st, logic fd, logic [PEER_W-1:0] pr, logic lt);
         peer_reply_type r;
         r.status = st;
         r.found  = fd;
         r.peer   = pr;
         r.last   = lt;
         replies_due = {replies_due, r};
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      // an accepted item beat: update the table and queue what it must produce
      function void note_item(logic [KIND_W-1:0] kind, logic [PEER_W-1:0] id,
                              logic [POS_W-1:0] px, logic [POS_W-1:0] py);
         int qx, qy, slot, n;
         qx = to_cell(px);
         qy = to_cell(py);
         n  = 0;
         case (kind)
            KIND_PLACE: begin
               places++;
               slot = slot_of(id);
               if (slot >= 0) begin
                  push_due((at_x[slot] != qx || at_y[slot] != qy) ? STAT_CHANGED : STAT_OK,
                           1'b0, '0, 1'b1);
                  at_x[slot] = qx;
                  at_y[slot] = qy;
               end else begin
                  slot = -1;
                  for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
                     if (!live[i]) slot = i;
                  if (slot < 0) begin
                     fulls++;
                     push_due(STAT_FULL, 1'b0, '0, 1'b1);
                  end else begin
                     live[slot] = 1'b1;
                     who[slot]  = id;
                     at_x[slot] = qx;
                     at_y[slot] = qy;
                     push_due(STAT_CHANGED, 1'b0, '0, 1'b1);
                  end
               end
            end
            KIND_REMOVE: begin
               removes++;
               slot = slot_of(id);
               if (slot < 0) push_due(STAT_ABSENT, 1'b0, '0, 1'b1);
               else begin
                  live[slot] = 1'b0;
                  push_due(STAT_OK, 1'b0, '0, 1'b1);
               end
            end
            KIND_QUERY: begin
               queries++;
               // table order, excluded peer skipped
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (live[i] && who[i] != id &&
                      at_x[i] - qx >= -REACH && at_x[i] - qx <= REACH &&
                      at_y[i] - qy >= -REACH && at_y[i] - qy <= REACH) begin
                     push_due(STAT_OK, 1'b1, who[i], 1'b0);
                     n++;
                  end
               end
               hits += n;
               if (n == 0) push_due(STAT_ABSENT, 1'b0, '0, 1'b1);
               else replies_due[replies_due.size() - 1].last = 1'b1;
            end
            default: ignored++;
         endcase
      endfunction

      // an accepted result beat against the oldest expectation
      function void check_beat(peer_reply_type got);
         peer_reply_type exp;
         beats++;
         if (replies_due.size() == 0) begin
            $error("unexpected result beat: status %0d found %0d peer %h last %0d",
                   got.status, got.found, got.peer, got.last);
            errors++;
            return;
         end
         exp = replies_due.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            errors++;
         end
         if (got.found !== exp.found) begin
            $error("found: expected %0d, actual %0d", exp.found, got.found);
            errors++;
         end
         if (got.peer !== exp.peer) begin
            $error("found_peer: expected %h, actual %h", exp.peer, got.peer);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last: expected %0d, actual %0d", exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // peer_id[31:0], pos_x[55:32], pos_y[79:56]
   logic [KIND_W-1:0]     req_tuser   = '0;   // kind[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // status[1:0], found_peer[33:2], zero pad
   logic [0:0]            rsp_tuser;          // found[0]
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [SIZE_W-1:0]     csr_wr_data = '0;

   peer_grid_tracker  sb;
   logic [PEER_W-1:0] id_pool [POOL_SIZE];
   longint            hot_x [3];
   longint            hot_y [3];
   int                src_calm = 0;
   int                snk_calm = 0;
   longint            cycles   = 0;
   int                sizes_run = 0;

   grid_neighbor_peer_table #(.MAX_PEERS(TABLE_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("grid_neighbor_peer_table test failed");
         $finish;
      end
   end

   // idle draw: usually a random gap, with occasional runs of back-to-back beats
   function automatic int pick_gap(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(5, 20);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // coordinate scattered within three cells of a hot spot, clamped to 24 bits
   function automatic logic [POS_W-1:0] spot_coord(longint hot);
      longint cs;
      longint v;
      cs = (sb.cell_size == 0) ? 1 : longint'(sb.cell_size);
      v  = hot + longint'($urandom_range(0, 6 * cs)) - 3 * cs;
      if (v > POS_MAX) v = POS_MAX;
      if (v < POS_MIN) v = POS_MIN;
      return v[POS_W-1:0];
   endfunction

   // one item beat; valid stays high across back-to-back beats
   task automatic send_item(logic [KIND_W-1:0] kind, logic [PEER_W-1:0] id,
                            logic [POS_W-1:0] px, logic [POS_W-1:0] py);
      int gap;
      gap = pick_gap(src_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({py, px, id});
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, id, px, py);
   endtask

   // drain, let the block settle, then load a new cell size
   task automatic load_cell_size(logic [SIZE_W-1:0] v);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.cell_size = v;
      sizes_run++;
   endtask

   // random mix around three hot spots, with some noise items
   task automatic run_phase(int place_pct, int remove_pct, int count);
      int r, h;
      logic [KIND_W-1:0] kind;
      logic [PEER_W-1:0] id;
      logic [POS_W-1:0]  px, py;
      hot_x[0] = longint'($signed(POS_W'($urandom())));
      hot_y[0] = longint'($signed(POS_W'($urandom())));
      hot_x[1] = 0;
      hot_y[1] = 0;
      hot_x[2] = $urandom_range(0, 1) ? POS_MAX - 600 : POS_MIN + 600;
      hot_y[2] = $urandom_range(0, 1) ? POS_MAX - 600 : POS_MIN + 600;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < place_pct) kind = KIND_PLACE;
         else if (r < place_pct + remove_pct) kind = KIND_REMOVE;
         else if (r < place_pct + remove_pct + 4) kind = KIND_NONE;
         else kind = KIND_QUERY;
         if ($urandom_range(0, 15) == 0) id = $urandom();
         else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
         if ($urandom_range(0, 7) == 0) begin
            px = POS_W'($urandom());
            py = POS_W'($urandom());
         end else begin
            h  = $urandom_range(0, 2);
            px = spot_coord(hot_x[h]);
            py = spot_coord(hot_y[h]);
         end
         send_item(kind, id, px, py);
      end
   endtask

   // result side: random stalls plus one long hold to back up the block
   initial begin
      int idle;
      peer_reply_type got;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (sb.beats == HOLD_AT) idle = HOLD_CYCLES;
         else idle = pick_gap(snk_calm);
         if (idle > 0) begin
            rsp_tready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.status = rsp_tdata[1:0];
         got.peer   = rsp_tdata[33:2];
         got.found  = rsp_tuser[0];
         got.last   = rsp_tlast;
         sb.check_beat(got);
      end
   end

   // stimulus
   initial begin
      sb = new();
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, move in place, exclusion, remove twice
      send_item(KIND_REMOVE, 32'd5, 24'h000000, 24'h000000);
      send_item(KIND_QUERY,  32'd0, 24'h000000, 24'h000000);
      send_item(KIND_NONE,   32'd5, 24'h123456, 24'hABCDEF);
      send_item(KIND_PLACE,  32'd0, 24'h800000, 24'h800000);
      send_item(KIND_PLACE,  32'hFFFF_FFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_item(KIND_PLACE,  32'd0, 24'h800000, 24'h800000);
      send_item(KIND_PLACE,  32'd0, 24'h800001, 24'h800001);
      send_item(KIND_PLACE,  32'd0, 24'h000000, 24'h000000);
      send_item(KIND_PLACE,  32'd1, 24'hFFFFFF, 24'hFFFFFF);
      send_item(KIND_PLACE,  32'd2, 24'h0002FF, 24'h000000);
      send_item(KIND_PLACE,  32'd3, 24'h000300, 24'hFFFE00);
      send_item(KIND_QUERY,  32'hFFFF_FFFF, 24'h000000, 24'h000000);
      send_item(KIND_QUERY,  32'd0, 24'h000000, 24'h000000);
      send_item(KIND_QUERY,  32'hFFFF_FFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_item(KIND_QUERY,  32'd7, 24'h7FFFFF, 24'h7FFFFF);
      send_item(KIND_REMOVE, 32'd1, 24'h000000, 24'h000000);
      send_item(KIND_REMOVE, 32'd1, 24'h000000, 24'h000000);
      send_item(KIND_QUERY,  32'd0, 24'h000000, 24'h000000);
      send_item(KIND_PLACE,  32'd1, 24'hFFFFFF, 24'h7FFFFF);
      send_item(KIND_NONE,   32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000);
      send_item(KIND_QUERY,  32'hAAAA_5555, 24'hFFFF00, 24'h000100);

      // random phases over a spread of cell sizes, fill and drain included
      load_cell_size(SIZE_W'(1));
      run_phase(50, 15, PHASE_ITEMS);
      load_cell_size('1);
      run_phase(85, 3, PHASE_ITEMS);
      load_cell_size('0);
      run_phase(40, 30, PHASE_ITEMS);
      load_cell_size(SIZE_W'(3));
      run_phase(60, 15, PHASE_ITEMS);
      load_cell_size(SIZE_W'($urandom_range(2, 4000)));
      run_phase(50, 15, PHASE_ITEMS);
      load_cell_size(CELL_SIZE_RESET);
      run_phase(30, 35, PHASE_ITEMS);

      // wind down
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d places (%0d table full), %0d removes, %0d queries, %0d ignored",
               sb.places, sb.fulls, sb.removes, sb.queries, sb.ignored);
      $display("checked %0d result beats with %0d neighbor hits over %0d cell size loads",
               sb.beats, sb.hits, sizes_run);
      if (sb.errors == 0) begin
         $display("grid_neighbor_peer_table test passed");
      end else begin
         $display("grid_neighbor_peer_table test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: grid_neighbor_peer_table.f
+incdir+sv
sv/gnpt_pkg.sv
sv/gnpt_div.sv
sv/gnpt_table.sv
sv/gnpt_ctrl.sv
sv/grid_neighbor_peer_table.sv
sv/gnpt_checker.sv
bench/tb_grid_neighbor_peer_table.sv
